// File: src/http_request_stream_parser_macros.svh
// Assertion helpers shared by the RTL
`ifndef HTTP_REQUEST_STREAM_PARSER_MACROS_SVH
`define HTTP_REQUEST_STREAM_PARSER_MACROS_SVH
// implication checked every cycle outside reset
`define HRSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define HRSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: src/hrsp_pkg.sv
`default_nettype none
package hrsp_pkg;
  localparam int LineMaxDefault = 128;
  localparam int QueueDepth = 4;

  typedef enum logic [3:0] {
    K_METHOD_BYTE = 4'd0, K_METHOD_END = 4'd1, K_TARGET_BYTE = 4'd2,
    K_TARGET_END = 4'd3, K_QUERY_BYTE = 4'd4, K_QUERY_END = 4'd5,
    K_TYPE_BYTE = 4'd6, K_TYPE_END = 4'd7, K_BODY_BYTE = 4'd8,
    K_REQ_END = 4'd9, K_ERROR = 4'd10
  } kind_t;

  typedef enum logic [1:0] {
    E_NONE = 2'd0, E_EOL = 2'd1, E_LINE_END = 2'd2, E_OVERFLOW = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    PH_METHOD = 3'd0, PH_TARGET = 3'd1, PH_QUERY = 3'd2, PH_VERSION = 3'd3,
    PH_NAME = 3'd4, PH_SPACE = 3'd5, PH_VALUE = 3'd6, PH_BODY = 3'd7
  } phase_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] data_value;
    logic [1:0] error_code;
    logic       last;
  } res_t;

  // up to three results per input byte
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
    res_t       r2;
  } bundle_t;

  localparam int NameTypeLen = 12;
  localparam int NameLengthLen = 14;

  function automatic logic [7:0] name_type_ch(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0: c = "c"; 4'd1: c = "o"; 4'd2: c = "n"; 4'd3: c = "t";
      4'd4: c = "e"; 4'd5: c = "n"; 4'd6: c = "t"; 4'd7: c = "-";
      4'd8: c = "t"; 4'd9: c = "y"; 4'd10: c = "p"; 4'd11: c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] name_length_ch(input logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0: c = "c"; 4'd1: c = "o"; 4'd2: c = "n"; 4'd3: c = "t";
      4'd4: c = "e"; 4'd5: c = "n"; 4'd6: c = "t"; 4'd7: c = "-";
      4'd8: c = "l"; 4'd9: c = "e"; 4'd10: c = "n"; 4'd11: c = "g";
      4'd12: c = "t"; 4'd13: c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

// File: src/hrsp_stream_if.sv
`default_nettype none
interface hrsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       new_connection;
  modport source (output valid, output rx_byte, output new_connection, input ready);
  modport sink (input valid, input rx_byte, input new_connection, output ready);
endinterface

interface hrsp_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [7:0] data_value;
  logic [1:0] error_code;
  logic       last;
  modport source (output valid, output kind, output data_value, output error_code,
                  output last, input ready);
  modport sink (input valid, input kind, input data_value, input error_code,
                input last, output ready);
endinterface
`default_nettype wire

// File: src/hrsp_front.sv
`default_nettype none
// Parser state machine: one byte in, a bundle of up to three results out.
module hrsp_front #(
  parameter int LINE_MAX = hrsp_pkg::LineMaxDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              new_connection,
  output hrsp_pkg::bundle_t      bundle,
  output logic                   bundle_valid
);
  import hrsp_pkg::*;
  localparam int CW = $clog2(LINE_MAX + 1);

  phase_t       phase, phase_next;
  logic         cr_pending, cr_pending_next;
  logic [CW-1:0] line_count, line_count_next;
  logic [CW-1:0] body_count, body_count_next;
  logic [15:0]  body_length, body_length_next;
  logic [15:0]  length_acc, length_acc_next;
  logic         digits_done, digits_done_next;
  logic [3:0]   name_pos, name_pos_next;
  logic [1:0]   name_flags, name_flags_next;
  logic         halted, halted_next;
  bundle_t      b;

  // 16-bit acc * 10 + digit, saturating
  logic [19:0] acc_mul;
  assign acc_mul = {1'b0, length_acc, 3'b000} + {3'b000, length_acc, 1'b0};

  always_comb begin
    phase_t ph;
    logic cr;
    logic [CW-1:0] lc;
    logic [CW-1:0] bc;
    logic [15:0] bl;
    logic [15:0] la;
    logic dd;
    logic [3:0] np;
    logic [1:0] nf;
    logic hl;
    logic [1:0] n;
    res_t rs [3];
    logic [7:0] c;
    logic do_feed;
    logic [7:0] lcc;
    logic [1:0] f;
    logic [19:0] v;
    ph = phase; cr = cr_pending; lc = line_count; bc = body_count;
    bl = body_length; la = length_acc; dd = digits_done; np = name_pos;
    nf = name_flags; hl = halted; n = 2'd0;
    for (int i = 0; i < 3; i++) rs[i] = '0;
    c = rx_byte; do_feed = 1'b0; lcc = 8'h00; f = 2'b00; v = '0;

    if (new_connection) begin
      ph = PH_METHOD; bl = '0; bc = '0; cr = 1'b0; lc = '0; np = '0; nf = 2'b11;
      la = '0; dd = 1'b0; hl = 1'b0;
    end

    if (!hl) begin
      if (ph == PH_BODY) begin
        bc = bc + 1'b1;
        rs[n] = '{kind: K_BODY_BYTE, data_value: rx_byte, error_code: E_NONE, last: 1'b0};
        n = n + 1'b1;
        if (16'(bc) == bl) begin
          rs[n] = '{kind: K_REQ_END, data_value: 8'h00, error_code: E_NONE, last: 1'b0};
          n = n + 1'b1;
          ph = PH_METHOD; bl = '0; cr = 1'b0; lc = '0; np = '0; nf = 2'b11;
          if (bc < CW'(LINE_MAX)) bc = '0;
        end
        if (bc >= CW'(LINE_MAX)) begin
          rs[n] = '{kind: K_ERROR, data_value: 8'h00, error_code: E_OVERFLOW, last: 1'b0};
          n = n + 1'b1; hl = 1'b1;
        end
      end else if (rx_byte == 8'h0A) begin
        if (!cr) begin
          rs[n] = '{kind: K_ERROR, data_value: 8'h00, error_code: E_LINE_END, last: 1'b0};
          n = n + 1'b1; hl = 1'b1;
        end else begin
          cr = 1'b0;
          case (ph)
            PH_VERSION: begin
              ph = PH_NAME; np = '0; nf = 2'b11;
            end
            PH_NAME: begin
              if (lc == CW'(1)) begin
                if (bl != 16'd0) begin
                  ph = PH_BODY; bc = '0;
                end else begin
                  rs[n] = '{kind: K_REQ_END, data_value: 8'h00, error_code: E_NONE,
                            last: 1'b0};
                  n = n + 1'b1;
                  ph = PH_METHOD; bl = '0; bc = '0; np = '0; nf = 2'b11;
                end
              end else begin
                rs[n] = '{kind: K_ERROR, data_value: 8'h00, error_code: E_EOL, last: 1'b0};
                n = n + 1'b1; hl = 1'b1;
              end
            end
            PH_VALUE: begin
              if (nf[0]) begin
                rs[n] = '{kind: K_TYPE_END, data_value: 8'h00, error_code: E_NONE,
                          last: 1'b0};
                n = n + 1'b1;
              end
              if (nf[1]) bl = la;
              ph = PH_NAME; np = '0; nf = 2'b11;
            end
            default: begin
              rs[n] = '{kind: K_ERROR, data_value: 8'h00, error_code: E_EOL, last: 1'b0};
              n = n + 1'b1; hl = 1'b1;
            end
          endcase
          lc = '0;
        end
      end else begin
        lc = lc + 1'b1;
        if (lc >= CW'(LINE_MAX)) begin
          rs[n] = '{kind: K_ERROR, data_value: 8'h00, error_code: E_OVERFLOW, last: 1'b0};
          n = n + 1'b1; hl = 1'b1;
        end else begin
          // a held CR is fed as data first, then this byte unless it is a CR; at most two feeds
          for (int k = 0; k < 2; k++) begin
            do_feed = 1'b0;
            if (k == 0) begin
              if (cr) begin
                cr = 1'b0; c = 8'h0D; do_feed = 1'b1;
              end
            end else begin
              if (rx_byte == 8'h0D) cr = 1'b1;
              else begin
                c = rx_byte; do_feed = 1'b1;
              end
            end
            if (do_feed) begin
              if (ph == PH_SPACE && c != 8'h20) ph = PH_VALUE;
              case (ph)
                PH_METHOD: begin
                  if (c == 8'h20) begin
                    rs[n] = '{kind: K_METHOD_END, data_value: 8'h00, error_code: E_NONE,
                              last: 1'b0};
                    ph = PH_TARGET;
                  end else begin
                    rs[n] = '{kind: K_METHOD_BYTE, data_value: c, error_code: E_NONE,
                              last: 1'b0};
                  end
                  n = n + 1'b1;
                end
                PH_TARGET: begin
                  if (c == 8'h20 || c == 8'h3F) begin
                    rs[n] = '{kind: K_TARGET_END, data_value: 8'h00, error_code: E_NONE,
                              last: 1'b0};
                    ph = (c == 8'h20) ? PH_VERSION : PH_QUERY;
                  end else begin
                    rs[n] = '{kind: K_TARGET_BYTE, data_value: c, error_code: E_NONE,
                              last: 1'b0};
                  end
                  n = n + 1'b1;
                end
                PH_QUERY: begin
                  if (c == 8'h20) begin
                    rs[n] = '{kind: K_QUERY_END, data_value: 8'h00, error_code: E_NONE,
                              last: 1'b0};
                    ph = PH_VERSION;
                  end else begin
                    rs[n] = '{kind: K_QUERY_BYTE, data_value: c, error_code: E_NONE,
                              last: 1'b0};
                  end
                  n = n + 1'b1;
                end
                PH_NAME: begin
                  if (c == 8'h3A) begin
                    f = 2'b00;
                    if (nf[0] && np == 4'(NameTypeLen)) f[0] = 1'b1;
                    if (nf[1] && np == 4'(NameLengthLen)) f[1] = 1'b1;
                    nf = f; la = '0; dd = 1'b0; ph = PH_SPACE;
                  end else begin
                    lcc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
                    if (np >= 4'(NameTypeLen) || name_type_ch(np) != lcc) nf[0] = 1'b0;
                    if (np >= 4'(NameLengthLen) || name_length_ch(np) != lcc) nf[1] = 1'b0;
                    if (np < 4'd15) np = np + 1'b1;
                  end
                end
                PH_VALUE: begin
                  if (nf[0]) begin
                    rs[n] = '{kind: K_TYPE_BYTE, data_value: c, error_code: E_NONE,
                              last: 1'b0};
                    n = n + 1'b1;
                  end
                  if (nf[1]) begin
                    if (!dd && c >= 8'h30 && c <= 8'h39) begin
                      // acc_mul is from the registered value; la is unchanged by
                      // an earlier feed in this cycle while in the value phase
                      v = acc_mul + {16'd0, c[3:0]};
                      la = (v > 20'd65535) ? 16'hFFFF : v[15:0];
                    end else begin
                      dd = 1'b1;
                    end
                  end
                end
                default: ;
              endcase
            end
          end
        end
      end
    end
    if (n != 2'd0) rs[n - 1'b1].last = 1'b1;

    phase_next = ph; cr_pending_next = cr; line_count_next = lc;
    body_count_next = bc; body_length_next = bl; length_acc_next = la;
    digits_done_next = dd; name_pos_next = np; name_flags_next = nf;
    halted_next = hl;
    b.n = n; b.r0 = rs[0]; b.r1 = rs[1]; b.r2 = rs[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_METHOD; cr_pending <= 1'b0; line_count <= '0; body_count <= '0;
      body_length <= '0; length_acc <= '0; digits_done <= 1'b0; name_pos <= '0;
      name_flags <= 2'b11; halted <= 1'b0;
    end else if (in_valid) begin
      phase <= phase_next; cr_pending <= cr_pending_next;
      line_count <= line_count_next; body_count <= body_count_next;
      body_length <= body_length_next; length_acc <= length_acc_next;
      digits_done <= digits_done_next; name_pos <= name_pos_next;
      name_flags <= name_flags_next; halted <= halted_next;
    end
  end

  assign bundle = b;
  assign bundle_valid = in_valid && (b.n != 2'd0);

  `include "http_request_stream_parser_macros.svh"
  `HRSP_ASSERT_IMP(a_halt_quiet, in_valid && halted && !new_connection, b.n == 2'd0, "halted output")
  `HRSP_ASSERT_IMP(a_line_bound, 1'b1, line_count <= CW'(LINE_MAX), "line count overran")
  `HRSP_ASSERT_NEXT(a_err_halts, in_valid && b.n != 2'd0 && b.r0.kind == K_ERROR, halted, "no halt")
endmodule
`default_nettype wire

// File: src/hrsp_back.sv
`default_nettype none
// Bundle queue plus serializer: drains up to three results per bundle.
module hrsp_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  hrsp_pkg::bundle_t push_data,
  output logic              space,
  hrsp_out_if.source        out_ch
);
  import hrsp_pkg::*;
  localparam int AW = $clog2(QueueDepth);

  bundle_t       mem [QueueDepth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic [1:0]    sub;
  bundle_t       head;
  res_t          cur;
  logic          pop_res, pop_bundle;

  assign head = mem[rd_ptr];
  always_comb begin
    case (sub)
      2'd0: cur = head.r0;
      2'd1: cur = head.r1;
      default: cur = head.r2;
    endcase
  end

  assign out_ch.valid = (count != '0);
  assign out_ch.kind = cur.kind;
  assign out_ch.data_value = cur.data_value;
  assign out_ch.error_code = cur.error_code;
  assign out_ch.last = cur.last;
  assign pop_res = out_ch.valid && out_ch.ready;
  assign pop_bundle = pop_res && cur.last;
  // a slot frees this cycle if the head bundle finishes
  assign space = (count < (AW + 1)'(QueueDepth)) || pop_bundle;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; count <= '0; sub <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop_bundle) begin
        rd_ptr <= rd_ptr + 1'b1; sub <= '0;
      end else if (pop_res) begin
        sub <= sub + 1'b1;
      end
      count <= count + (AW + 1)'(push) - (AW + 1)'(pop_bundle);
    end
  end

  `include "http_request_stream_parser_macros.svh"
  `HRSP_ASSERT_IMP(a_no_overflow, push, space, "queue overflow")
  `HRSP_ASSERT_IMP(a_sub_in_range, out_ch.valid, sub < head.n, "serializer past bundle")
  `HRSP_ASSERT_IMP(a_count_bound, 1'b1, count <= (AW + 1)'(QueueDepth), "count overran")
endmodule
`default_nettype wire

// File: src/http_request_stream_parser.sv
// HTTP request stream parser.
// in_ch: one received byte per beat (rx_byte) and new_connection, which
// restarts the parser before that byte is parsed.
// out_ch: tagged result beats (kind, data_value, error_code, last); last
// marks the final result caused by one input byte. A byte may cause none.
// Throughput: one input byte per cycle while the queue has space. A byte
// with two or three results drains one result per output beat.
// Latency: with an empty queue, results of a byte appear the cycle after it
// is accepted.
// Between parser and output sits a four-bundle queue; when the receiver
// stalls, the queue fills and in_ch.ready drops, holding the parser state.
// Reset (synchronous rst) empties the queue and returns the parser to the
// method phase with counters clear and the halt released. After an error
// the parser drops all bytes until new_connection.
`default_nettype none
module http_request_stream_parser #(
  parameter int LINE_MAX = hrsp_pkg::LineMaxDefault
) (
  input wire logic   clk,
  input wire logic   rst,
  hrsp_in_if.sink    in_ch,
  hrsp_out_if.source out_ch
);
  import hrsp_pkg::*;
  bundle_t bundle;
  logic    bundle_valid, space, accept;

  assign in_ch.ready = space;
  assign accept = in_ch.valid && space;

  hrsp_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk, .rst, .in_valid(accept), .rx_byte(in_ch.rx_byte),
    .new_connection(in_ch.new_connection), .bundle, .bundle_valid
  );

  hrsp_back u_back (
    .clk, .rst, .push(bundle_valid), .push_data(bundle), .space, .out_ch
  );
endmodule
`default_nettype wire
